[hw/rtl/float_log10_table_interpolator_top_defines.svh]
// Assertion macros for the checker of the log10 interpolator
`ifndef FLOAT_LOG10_TABLE_INTERPOLATOR_TOP_DEFINES_SVH
`define FLOAT_LOG10_TABLE_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FLTI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FLTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/flti_pkg.sv]
// Constants, types and the log10 table generator for the log10 interpolator
package flti_pkg;

    localparam int INDEX_BITS    = 10;
    localparam int FRACTION_BITS = 24;
    localparam int LOW_BITS      = 23 - INDEX_BITS;
    localparam int TABLE_DEPTH   = (1 << INDEX_BITS) + 1;
    localparam int ADDR_W        = INDEX_BITS + 1;
    localparam int TABLE_W       = FRACTION_BITS - 1;
    localparam int EXP_W         = 9;
    localparam int CK_W          = EXP_W + TABLE_W + 1;
    localparam int PROD_W        = TABLE_W + LOW_BITS;
    localparam int LOG_W         = 35;
    localparam int OUT_TDATA_W   = ((LOG_W + 7) / 8) * 8;
    localparam int EXP_BIAS      = 127;
    localparam int NONPOS_VALUE  = 1000;

    localparam logic [63:0]      NONPOS_MAG = 64'(NONPOS_VALUE) << FRACTION_BITS;
    localparam logic [LOG_W-1:0] NONPOS_LOG = LOG_W'(64'd0 - NONPOS_MAG);

    typedef logic [TABLE_W-1:0] log_table_t [TABLE_DEPTH];

    // log2 of a Q1.62 value in [1, 2], result in Q0.60
    function automatic logic [63:0] log2_q60(input logic [63:0] v_in);
        logic [63:0]  v;
        logic [63:0]  r;
        logic [127:0] p;
        int           k;
        v = v_in;
        r = 64'd0;
        if (v[63])
        begin
            r = 64'd1 << 60;
            v = v >> 1;
        end
        for (k = 1; k <= 60; k++)
        begin
            p = {64'd0, v} * {64'd0, v};
            v = p[125:62];
            if (v[63])
            begin
                v = v >> 1;
                r = r | (64'd1 << (60 - k));
            end
        end
        return r;
    endfunction

    // log10(2) in Q0.62
    function automatic logic [63:0] calc_log10_two();
        logic [63:0] l2ten;
        logic [63:0] rem;
        logic [63:0] l10;
        int          k;
        l2ten = (64'd3 << 60) + log2_q60(64'd5 << 60);
        rem   = 64'd1 << 60;
        l10   = 64'd0;
        for (k = 1; k <= 62; k++)
        begin
            rem = rem << 1;
            if (rem >= l2ten)
            begin
                rem = rem - l2ten;
                l10 = l10 | (64'd1 << (62 - k));
            end
        end
        return l10;
    endfunction

    function automatic logic [TABLE_W-1:0] calc_exp_const();
        logic [63:0] t;
        t = (calc_log10_two() + (64'd1 << (61 - FRACTION_BITS))) >> (62 - FRACTION_BITS);
        return t[TABLE_W-1:0];
    endfunction

    function automatic log_table_t build_log_table();
        log_table_t   tbl;
        logic [63:0]  l10;
        logic [63:0]  v;
        logic [63:0]  t;
        logic [127:0] p;
        int           i;
        l10 = calc_log10_two();
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            v      = (64'd1 << 62) + (64'(i) << (62 - INDEX_BITS));
            p      = {64'd0, log2_q60(v)} * {64'd0, l10};
            t      = p[127:64] + (64'd1 << (57 - FRACTION_BITS));
            t      = t >> (58 - FRACTION_BITS);
            tbl[i] = t[TABLE_W-1:0];
        end
        return tbl;
    endfunction

    localparam logic [TABLE_W-1:0] EXP_CONST = calc_exp_const();
    localparam log_table_t         LOG_TABLE = build_log_table();

endpackage

[hw/rtl/float_log10_table_interpolator_top.sv]
// Top level of the single-precision log10 table interpolator
// Pipeline stages from input item to result item: ROM read, multiply, sum.
// Throughput: one item per cycle unless stalled; two ROM read ports and pipeline set it.
// Each stage advances when the one after it is empty or moving, so bubbles are filled.
// Reset: asynchronous, active low; clears all stage valid bits, the ROM needs no fill.
module float_log10_table_interpolator_top
    import flti_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // [31:0] float_bits
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [34:0] log_value, rest zero
    output logic                   m_tuser    // [0] nonpositive
);

    logic en1;
    logic en2;
    logic en3;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    logic                    np1_reg;
    logic signed [EXP_W-1:0] exp1_reg;
    logic [LOW_BITS-1:0]     frac1_reg;
    logic [TABLE_W-1:0]      lo1_reg;
    logic [TABLE_W-1:0]      hi1_reg;

    logic                    np2_reg;
    logic signed [CK_W-1:0]  ck2_reg;
    logic [TABLE_W-1:0]      lo2_reg;
    logic [TABLE_W-1:0]      interp2_reg;

    logic                    np3_reg;
    logic [LOG_W-1:0]        log3_reg;

    logic [30:0]             mag;
    logic                    np1_next;
    logic signed [EXP_W-1:0] exp1_next;
    logic [ADDR_W-1:0]       addr_lo;
    logic [ADDR_W-1:0]       addr_hi;

    logic [TABLE_W-1:0]      diff;
    logic [PROD_W-1:0]       prod;
    logic [TABLE_W-1:0]      interp2_next;
    logic signed [CK_W-1:0]  ck2_next;

    logic [LOG_W-1:0]        sum;
    logic [LOG_W-1:0]        log3_next;

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // decode the float fields
    assign mag       = s_tdata[30:0];
    assign np1_next  = (mag == 31'd0) || (s_tdata[31] && (mag <= 31'h7f80_0000));
    assign exp1_next = $signed({1'b0, s_tdata[30:23]}) - EXP_W'(EXP_BIAS);
    assign addr_lo   = {1'b0, s_tdata[22:LOW_BITS]};
    assign addr_hi   = addr_lo + ADDR_W'(1);

    // interpolate and scale the exponent
    assign diff         = hi1_reg - lo1_reg;
    assign prod         = PROD_W'(diff) * PROD_W'(frac1_reg);
    assign interp2_next = prod[PROD_W-1:LOW_BITS];
    assign ck2_next     = CK_W'(exp1_reg) * CK_W'($signed({1'b0, EXP_CONST}));

    // sum and select
    assign sum       = LOG_W'(ck2_reg) + LOG_W'(lo2_reg) + LOG_W'(interp2_reg);
    assign log3_next = np2_reg ? NONPOS_LOG : sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            np1_reg   <= np1_next;
            exp1_reg  <= exp1_next;
            frac1_reg <= s_tdata[LOW_BITS-1:0];
            lo1_reg   <= LOG_TABLE[addr_lo];
            hi1_reg   <= LOG_TABLE[addr_hi];
        end
        if (en2)
        begin
            np2_reg     <= np1_reg;
            ck2_reg     <= ck2_next;
            lo2_reg     <= lo1_reg;
            interp2_reg <= interp2_next;
        end
        if (en3)
        begin
            np3_reg  <= np2_reg;
            log3_reg <= log3_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(OUT_TDATA_W - LOG_W){1'b0}}, log3_reg};
    assign m_tuser  = np3_reg;

endmodule

[hw/rtl/flti_checker.sv]
// Port-level checker for the log10 interpolator and its bind
`include "float_log10_table_interpolator_top_defines.svh"

module flti_checker
    import flti_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [31:0]            s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser
);

    `FLTI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")
    `FLTI_ASSERT_NOW(a_nonpos_value, m_tvalid && m_tuser, m_tdata[LOG_W-1:0] == NONPOS_LOG, "nonpositive item without the fixed value")
    `FLTI_ASSERT_NOW(a_empty_ready, !m_tvalid, s_tready, "input stalled with empty output")
    `FLTI_ASSERT_NOW(a_zero_latency, $past(s_tvalid && s_tready && (s_tdata[30:0] == 31'd0), 3) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1) && $past(m_tready, 2) && $past(m_tready, 1), m_tvalid && m_tuser, "zero item not delivered after three cycles")

endmodule

bind float_log10_table_interpolator_top flti_checker u_flti_checker (.*);
